// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg
// Beat types and fixed constants of the RTC snapshot to epoch seconds unit.
// ----------------------------------------------------------------------------
package rse_pkg;

  // Status register B bit positions
  localparam int STB_BINARY_BIT = 2;
  localparam int STB_H24_BIT    = 1;

  // Calendar and time constants
  localparam int EPOCH_YEAR     = 1970;
  localparam int SEC_PER_DAY    = 86400;
  localparam int SEC_PER_HOUR   = 3600;
  localparam int SEC_PER_MIN    = 60;
  localparam int HOURS_HALF_DAY = 12;
  localparam int YEARS_PER_CEN  = 100;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int MONTHS_MAX     = 12;
  localparam int DAY_MAX        = 31;
  // Gregorian days from year 1 through the end of 1969
  localparam int DAYS_TO_EPOCH  = 719162;

  // Division by 25 via reciprocal: exact for dividends below 43690
  localparam int RECIP_DIV      = 25;
  localparam int RECIP25        = 10486;
  localparam int RECIP25_SHIFT  = 18;

  localparam int                    CEN_FALLBACK_RST = 21;
  localparam logic [13:0]           YEAR_MAX         = '1;
  localparam logic [37:0]           EPOCH_MAX        = '1;

  typedef struct packed {
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
    logic [7:0] raw_century;
    logic [7:0] status_b;
  } in_beat_t;

  typedef struct packed {
    logic [37:0] epoch_seconds;
    logic [13:0] full_year;
    logic        date_error;
  } out_beat_t;

  // Two-digit BCD byte to binary, no digit check
  function automatic logic [7:0] bcd8(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'b0000, b[7:4]};
    return {4'b0000, b[3:0]} + (hi << 3) + (hi << 1);
  endfunction

  // Days before the first of a month (1..12); other codes give zero
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rse_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rse_in_if
// Snapshot channel: valid/ready handshake carrying one raw clock snapshot.
// ----------------------------------------------------------------------------
interface rse_in_if;
  logic             valid;
  logic             ready;
  rse_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rse_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rse_out_if
// Result channel: valid/ready handshake carrying epoch seconds and year.
// ----------------------------------------------------------------------------
interface rse_out_if;
  logic              valid;
  logic              ready;
  rse_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rtc_snapshot_to_epoch_seconds_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_snapshot_to_epoch_seconds_unit
// Converts a raw CMOS clock snapshot into seconds since 1970 and full year.
// ----------------------------------------------------------------------------
//  channel    dir  handshake          payload
//  in_snap    in   valid/ready        8 raw clock bytes (rse_pkg::in_beat_t)
//  out_epoch  out  valid/ready        epoch_seconds, full_year, date_error
//  cfg_wr_*   in   write enable only  fallback_century (7 bits, reset 21)
//
//  Five register stages: decode, divide-by-25 quotients and time of day,
//  day count, day-to-seconds multiply, sum and saturate into the output
//  register. One beat is taken every cycle unless a stall fills every stage.
//  Each stage advances when it is empty or the stage after it advances, so a
//  stall on out_epoch backs up stage by stage and bubbles close up.
//  rst_n clears the stage valid bits and reloads fallback_century.
// ----------------------------------------------------------------------------
module rtc_snapshot_to_epoch_seconds_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [6:0] cfg_wr_data,
  rse_in_if.sink          in_snap,
  rse_out_if.source       out_epoch
);

  `include "assert_macros.svh"

  typedef struct packed {
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [3:0]  mon;
    logic        err;
    logic [14:0] year;
    logic [13:0] full_year;
  } s1_t;

  typedef struct packed {
    logic [19:0] tod;
    logic [7:0]  day;
    logic [8:0]  dbm;
    logic        after_feb;
    logic        err;
    logic        year_gt;
    logic [14:0] m;
    logic [8:0]  q100;
    logic [6:0]  q400;
    logic [13:0] full_year;
  } s2_t;

  typedef struct packed {
    logic [19:0] tod;
    logic [23:0] days;
    logic        err;
    logic [13:0] full_year;
  } s3_t;

  typedef struct packed {
    logic [19:0] tod;
    logic [40:0] prod;
    logic        err;
    logic [13:0] full_year;
  } s4_t;

  logic [6:0] fallback_century_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  rse_pkg::out_beat_t s5_r, s5_nxt;

  // Hold the fallback century register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_century_r <= 7'(rse_pkg::CEN_FALLBACK_RST);
    end else if (cfg_wr_en) begin
      fallback_century_r <= cfg_wr_data;
    end
  end

  // Advance a stage when it is empty or its successor advances
  assign en5 = !v5_r || out_epoch.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_snap.ready   = en1;
  assign out_epoch.valid = v5_r;
  assign out_epoch.data  = s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_snap.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: decode BCD, hour mode, full year and date check
  always_comb begin
    logic       bin;
    logic       h24;
    logic [7:0] mon_d;
    logic [7:0] day_d;
    logic [7:0] yr_d;
    logic [7:0] cen_d;
    logic [7:0] hour_d;
    logic [6:0] hour_lo;
    logic [6:0] hour_base;
    logic [6:0] fb_c;
    logic [7:0] cen_sel;
    logic [14:0] year;
    rse_pkg::in_beat_t d;

    d       = in_snap.data;
    bin     = d.status_b[rse_pkg::STB_BINARY_BIT];
    h24     = d.status_b[rse_pkg::STB_H24_BIT];
    hour_lo = {3'b000, d.raw_hour[3:0]} + {1'b0, d.raw_hour[6:4], 3'b000}
            + {3'b000, d.raw_hour[6:4], 1'b0};

    s1_nxt.sec = bin ? d.raw_second : rse_pkg::bcd8(d.raw_second);
    s1_nxt.min = bin ? d.raw_minute : rse_pkg::bcd8(d.raw_minute);
    hour_d     = bin ? d.raw_hour   : {d.raw_hour[7], hour_lo};
    day_d      = bin ? d.raw_day    : rse_pkg::bcd8(d.raw_day);
    mon_d      = bin ? d.raw_month  : rse_pkg::bcd8(d.raw_month);
    yr_d       = bin ? d.raw_year   : rse_pkg::bcd8(d.raw_year);
    cen_d      = bin ? d.raw_century : rse_pkg::bcd8(d.raw_century);

    // Map 12 AM to hour zero and add the PM half
    hour_base = (hour_d[6:0] == 7'(rse_pkg::HOURS_HALF_DAY)) ? 7'd0 : hour_d[6:0];
    if (h24) begin
      s1_nxt.hour = hour_d;
    end else begin
      s1_nxt.hour = {1'b0, hour_base}
                  + (hour_d[7] ? 8'(rse_pkg::HOURS_HALF_DAY) : 8'd0);
    end

    // Century byte, else the configured century
    fb_c    = (fallback_century_r == 7'd0) ? 7'd1 : fallback_century_r;
    cen_sel = (d.raw_century != 8'd0) ? cen_d : {1'b0, fb_c - 7'd1};
    year    = {7'b0, cen_sel} * 15'(rse_pkg::YEARS_PER_CEN) + {7'b0, yr_d};

    s1_nxt.year      = year;
    s1_nxt.full_year = year[14] ? rse_pkg::YEAR_MAX : year[13:0];
    s1_nxt.day       = day_d;
    s1_nxt.mon       = mon_d[3:0];
    s1_nxt.err       = (mon_d == 8'd0) || (mon_d > 8'(rse_pkg::MONTHS_MAX))
                    || (day_d == 8'd0) || (day_d > 8'(rse_pkg::DAY_MAX));
  end

  // Stage 2: quotients of (year-1)/100 and /400, time of day, month offset
  always_comb begin
    logic [14:0] m;
    logic [26:0] p100;
    logic [24:0] p400;

    m    = s1_r.year - 15'd1;
    p100 = {14'b0, m[14:2]} * 27'(rse_pkg::RECIP25);
    p400 = {14'b0, m[14:4]} * 25'(rse_pkg::RECIP25);

    s2_nxt.m         = m;
    s2_nxt.q100      = p100[26:rse_pkg::RECIP25_SHIFT];
    s2_nxt.q400      = p400[24:rse_pkg::RECIP25_SHIFT];
    s2_nxt.tod       = {12'b0, s1_r.hour} * 20'(rse_pkg::SEC_PER_HOUR)
                     + {12'b0, s1_r.min} * 20'(rse_pkg::SEC_PER_MIN)
                     + {12'b0, s1_r.sec};
    s2_nxt.day       = s1_r.day;
    s2_nxt.dbm       = rse_pkg::days_before_month(s1_r.mon);
    s2_nxt.after_feb = (s1_r.mon > 4'd2);
    s2_nxt.err       = s1_r.err;
    s2_nxt.year_gt   = (s1_r.year > 15'(rse_pkg::EPOCH_YEAR));
    s2_nxt.full_year = s1_r.full_year;
  end

  // Stage 3: leap test and day count since the epoch
  always_comb begin
    logic [12:0] r100;
    logic [10:0] r400;
    logic        y4;
    logic        y100;
    logic        y400;
    logic        leap;
    logic [24:0] dsum;
    logic [23:0] dyear;

    r100 = s2_r.m[14:2] - {4'b0, s2_r.q100} * 13'(rse_pkg::RECIP_DIV);
    r400 = s2_r.m[14:4] - {4'b0, s2_r.q400} * 11'(rse_pkg::RECIP_DIV);
    // The year is m+1: it divides by 4, 100, 400 when m sits one short
    y4   = (s2_r.m[1:0] == 2'b11);
    y100 = y4 && (r100 == 13'(rse_pkg::RECIP_DIV - 1));
    y400 = (s2_r.m[3:0] == 4'hF) && (r400 == 11'(rse_pkg::RECIP_DIV - 1));
    leap = (y4 && !y100) || y400;

    dsum  = {10'b0, s2_r.m} * 25'(rse_pkg::DAYS_PER_YEAR) + {12'b0, s2_r.m[14:2]}
          - {16'b0, s2_r.q100} + {18'b0, s2_r.q400} - 25'(rse_pkg::DAYS_TO_EPOCH);
    dyear = s2_r.year_gt ? dsum[23:0] : 24'd0;

    s3_nxt.days      = dyear + {15'b0, s2_r.dbm} + {23'b0, s2_r.after_feb && leap}
                     + {16'b0, s2_r.day - 8'd1};
    s3_nxt.tod       = s2_r.tod;
    s3_nxt.err       = s2_r.err;
    s3_nxt.full_year = s2_r.full_year;
  end

  // Stage 4: days to seconds
  always_comb begin
    s4_nxt.prod      = {17'b0, s3_r.days} * 41'(rse_pkg::SEC_PER_DAY);
    s4_nxt.tod       = s3_r.tod;
    s4_nxt.err       = s3_r.err;
    s4_nxt.full_year = s3_r.full_year;
  end

  // Stage 5: add time of day, saturate, drop to zero on a date error
  always_comb begin
    logic [40:0] sum;

    sum = s4_r.prod + {21'b0, s4_r.tod};
    if (s4_r.err) begin
      s5_nxt.epoch_seconds = 38'd0;
    end else if (sum > {3'b000, rse_pkg::EPOCH_MAX}) begin
      s5_nxt.epoch_seconds = rse_pkg::EPOCH_MAX;
    end else begin
      s5_nxt.epoch_seconds = sum[37:0];
    end
    s5_nxt.full_year  = s4_r.full_year;
    s5_nxt.date_error = s4_r.err;
  end

  // Load stage payloads on advance
  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
    if (en4) s4_r <= s4_nxt;
    if (en5) s5_r <= s5_nxt;
  end

  `ASSERT_IMPL(a_err_zero_secs, out_epoch.valid && out_epoch.data.date_error,
               out_epoch.data.epoch_seconds == 38'd0, "date error with nonzero seconds")
  `ASSERT_NEXT(a_no_drop_s4, v4_r && en5, v5_r, "beat lost between stages 4 and 5")
  `ASSERT_IMPL(a_full_when_stalled, !in_snap.ready,
               v1_r && v2_r && v3_r && v4_r && v5_r, "input stalled with a free stage")

endmodule
`default_nettype wire

// ===== test/rtc_snapshot_to_epoch_seconds_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtc_snapshot_to_epoch_seconds_unit_tb
// Drives raw clock snapshots into the unit and checks every result beat
// against an in-bench calculation of epoch seconds, full year and date error.
// A directed set covers the calendar corners. Random phases follow, each
// under its own fallback century. Both channels idle at random, and one
// phase holds the result channel off long enough to back up the input.
// ----------------------------------------------------------------------------
module rtc_snapshot_to_epoch_seconds_unit_tb;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned HOLD_CYCLES      = 150;
  localparam int unsigned RANDOM_PER_PHASE = 200;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned SETTLE_CYCLES    = 8;

  // Status register B settings used by the directed snapshots
  localparam logic [7:0] STB_BCD_12H = 8'h00;
  localparam logic [7:0] STB_BCD_24H = 8'h02;
  localparam logic [7:0] STB_BIN_12H = 8'h04;
  localparam logic [7:0] STB_BIN_24H = 8'h06;
  localparam logic [7:0] HOUR_PM     = 8'h80;

  // Expected result beats of accepted snapshots, oldest first
  class epoch_ledger;
    rse_pkg::out_beat_t pending[$];
    int unsigned        century_setting;
    int unsigned        failures;

    function new();
      century_setting = rse_pkg::CEN_FALLBACK_RST;
      failures = 0;
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    function int unsigned bcd_to_bin(logic [7:0] b);
      return int'(b[3:0]) + int'(b[7:4]) * 10;
    endfunction

    // Days from year 1 through the end of year n
    function longint unsigned days_through_year(int unsigned n);
      longint unsigned m;
      m = n;
      return m * 365 + m / 4 - m / 100 + m / 400;
    endfunction

    function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Days in the months ahead of mon, in a common year
    function int unsigned days_ahead_of_month(int unsigned mon);
      int unsigned sum;
      sum = 0;
      for (int unsigned m = 1; m < mon; m++) begin
        if (m == 2) sum += 28;
        else if (m == 4 || m == 6 || m == 9 || m == 11) sum += 30;
        else sum += 31;
      end
      return sum;
    endfunction

    function rse_pkg::out_beat_t predict_epoch(rse_pkg::in_beat_t s);
      int unsigned        sec, mnt, hr, dy, mon, yr, cen, base_cen, year;
      longint unsigned    days, total;
      bit                 pm, bad_date;
      rse_pkg::out_beat_t r;
      sec = s.raw_second;
      mnt = s.raw_minute;
      hr  = s.raw_hour;
      dy  = s.raw_day;
      mon = s.raw_month;
      yr  = s.raw_year;
      cen = s.raw_century;
      // Decode BCD; the hour keeps its PM flag apart from the digits
      if (!s.status_b[rse_pkg::STB_BINARY_BIT]) begin
        sec = bcd_to_bin(s.raw_second);
        mnt = bcd_to_bin(s.raw_minute);
        hr  = int'(s.raw_hour[3:0]) + int'(s.raw_hour[6:4]) * 10
            + (s.raw_hour[7] ? int'(HOUR_PM) : 0);
        dy  = bcd_to_bin(s.raw_day);
        mon = bcd_to_bin(s.raw_month);
        yr  = bcd_to_bin(s.raw_year);
        if (cen != 0) cen = bcd_to_bin(s.raw_century);
      end
      // Fold 12-hour time into 0..23: twelve is zero, PM adds twelve
      if (!s.status_b[rse_pkg::STB_H24_BIT]) begin
        pm = hr[7];
        hr = hr & (int'(HOUR_PM) - 1);
        if (hr == rse_pkg::HOURS_HALF_DAY) hr = 0;
        if (pm) hr += rse_pkg::HOURS_HALF_DAY;
      end
      if (cen != 0) begin
        year = yr + cen * rse_pkg::YEARS_PER_CEN;
      end else begin
        base_cen = (century_setting == 0) ? 1 : century_setting;
        year = yr + (base_cen - 1) * rse_pkg::YEARS_PER_CEN;
      end
      bad_date = (mon < 1) || (mon > rse_pkg::MONTHS_MAX)
              || (dy < 1) || (dy > rse_pkg::DAY_MAX);
      if (bad_date) begin
        total = 0;
      end else begin
        days = 0;
        if (year > rse_pkg::EPOCH_YEAR)
          days = days_through_year(year - 1)
               - days_through_year(rse_pkg::EPOCH_YEAR - 1);
        days += days_ahead_of_month(mon);
        if (mon > 2 && leap_year(year)) days += 1;
        days += dy - 1;
        total = days * rse_pkg::SEC_PER_DAY + longint'(hr) * rse_pkg::SEC_PER_HOUR
              + longint'(mnt) * rse_pkg::SEC_PER_MIN + sec;
        if (total > longint'(rse_pkg::EPOCH_MAX)) total = longint'(rse_pkg::EPOCH_MAX);
      end
      r.epoch_seconds = total[37:0];
      r.full_year     = (year > int'(rse_pkg::YEAR_MAX)) ? rse_pkg::YEAR_MAX : year[13:0];
      r.date_error    = bad_date;
      return r;
    endfunction

    function void note_snapshot(rse_pkg::in_beat_t s);
      pending.push_back(predict_epoch(s));
    endfunction

    function void flag(string field, longint unsigned want, longint unsigned got);
      failures++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(rse_pkg::out_beat_t got);
      rse_pkg::out_beat_t want;
      if (pending.size() == 0) begin
        flag("unexpected beat epoch_seconds", 0, got.epoch_seconds);
        return;
      end
      want = pending.pop_front();
      if (want.epoch_seconds !== got.epoch_seconds)
        flag("epoch_seconds", want.epoch_seconds, got.epoch_seconds);
      if (want.full_year !== got.full_year)
        flag("full_year", want.full_year, got.full_year);
      if (want.date_error !== got.date_error)
        flag("date_error", want.date_error, got.date_error);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  bit          long_hold_req;
  int unsigned send_quiet;
  int unsigned take_quiet;
  int unsigned cycle_count;
  epoch_ledger ledger;

  rse_in_if  in_snap ();
  rse_out_if out_epoch ();

  rtc_snapshot_to_epoch_seconds_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_snap     (in_snap),
    .out_epoch   (out_epoch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Two decimal digits of v as a BCD or binary byte
  function automatic logic [7:0] pack_digits(int unsigned v, bit binary);
    return binary ? 8'(v) : {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic rse_pkg::in_beat_t snap(logic [7:0] sec, logic [7:0] mnt,
                                             logic [7:0] hr, logic [7:0] dy,
                                             logic [7:0] mon, logic [7:0] yr,
                                             logic [7:0] cen, logic [7:0] stb);
    rse_pkg::in_beat_t s;
    s.raw_second  = sec;
    s.raw_minute  = mnt;
    s.raw_hour    = hr;
    s.raw_day     = dy;
    s.raw_month   = mon;
    s.raw_year    = yr;
    s.raw_century = cen;
    s.status_b    = stb;
    return s;
  endfunction

  // Mostly well-formed snapshots, some with one field broken, some pure noise
  function automatic rse_pkg::in_beat_t random_snapshot();
    rse_pkg::in_beat_t s;
    bit                binary, h24;
    int unsigned       pick;
    s = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 12) return s;
    binary = 1'($urandom_range(0, 1));
    h24 = 1'($urandom_range(0, 1));
    s.status_b[rse_pkg::STB_BINARY_BIT] = binary;
    s.status_b[rse_pkg::STB_H24_BIT] = h24;
    s.raw_second = pack_digits($urandom_range(0, 59), binary);
    s.raw_minute = pack_digits($urandom_range(0, 59), binary);
    if (h24) begin
      s.raw_hour = pack_digits($urandom_range(0, 23), binary);
    end else begin
      s.raw_hour = pack_digits($urandom_range(1, 12), binary);
      s.raw_hour[7] = 1'($urandom_range(0, 1));
    end
    s.raw_day   = pack_digits($urandom_range(1, 31), binary);
    s.raw_month = pack_digits($urandom_range(1, 12), binary);
    s.raw_year  = pack_digits($urandom_range(0, 99), binary);
    case ($urandom_range(0, 3))
      0: s.raw_century = 8'h00;
      1: s.raw_century = pack_digits($urandom_range(19, 21), binary);
      default: s.raw_century = pack_digits($urandom_range(1, 99), binary);
    endcase
    // Break one field of some snapshots
    if (pick < 26) begin
      case ($urandom_range(0, 3))
        0: s.raw_month = pack_digits($urandom_range(0, 1) ? 0 : $urandom_range(13, 99), binary);
        1: s.raw_day = pack_digits($urandom_range(0, 1) ? 0 : $urandom_range(32, 99), binary);
        2: s.raw_hour = 8'($urandom);
        default: s.raw_second = 8'($urandom);
      endcase
    end
    return s;
  endfunction

  // Offer one snapshot after a random gap and hold it until accepted
  task automatic send_snapshot(input rse_pkg::in_beat_t s);
    int unsigned gap;
    if (send_quiet > 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) send_quiet = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_snap.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_snap.valid <= 1'b1;
    in_snap.data  <= s;
    do @(posedge clk); while (!in_snap.ready);
  endtask

  // Drop valid and wait until every expected beat has come back
  task automatic drain_results();
    in_snap.valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_century(input logic [6:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.century_setting = v;
  endtask

  // Note accepted snapshots and check result beats
  always @(posedge clk) begin
    if (rst_n && in_snap.valid && in_snap.ready) ledger.note_snapshot(in_snap.data);
    if (rst_n && out_epoch.valid && out_epoch.ready) ledger.check_result(out_epoch.data);
  end

  // Result side: random stalls, quiet stretches, and a long hold on request
  initial begin
    int unsigned stall;
    out_epoch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        out_epoch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (take_quiet > 0) begin
          take_quiet--;
          stall = 0;
        end else begin
          stall = $urandom_range(0, 6);
          if ($urandom_range(0, 15) == 0) take_quiet = $urandom_range(20, 60);
        end
        if (stall > 0) begin
          out_epoch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_epoch.ready <= 1'b1;
        do @(posedge clk); while (!out_epoch.valid);
      end
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rtc_snapshot_to_epoch_seconds_unit test failed");
    $finish;
  end

  initial begin
    logic [6:0] century_plan [PHASES];
    ledger = new();
    long_hold_req = 1'b0;
    send_quiet = 0;
    take_quiet = 0;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_snap.valid <= 1'b0;
    in_snap.data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed snapshots under the reset century
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, STB_BCD_12H));
    send_snapshot(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // Epoch origin
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19, STB_BCD_24H));
    // Midnight, noon and 11 PM in 12-hour mode
    send_snapshot(snap(8'h30, 8'h45, 8'h12, 8'h15, 8'h03, 8'h24, 8'h20, STB_BCD_12H));
    send_snapshot(snap(8'h30, 8'h45, 8'h92, 8'h15, 8'h03, 8'h24, 8'h20, STB_BCD_12H));
    send_snapshot(snap(8'h59, 8'h59, 8'h91, 8'h15, 8'h03, 8'h24, 8'h20, STB_BCD_12H));
    // Binary fields, 24-hour and 12-hour with PM
    send_snapshot(snap(8'd7, 8'd14, 8'd3, 8'd19, 8'd1, 8'd38, 8'd20, STB_BIN_24H));
    send_snapshot(snap(8'd7, 8'd14, HOUR_PM | 8'd11, 8'd19, 8'd1, 8'd38, 8'd20, STB_BIN_12H));
    // Hour zero in 12-hour mode is left as it is
    send_snapshot(snap(8'd0, 8'd0, 8'd0, 8'd1, 8'd6, 8'd10, 8'd20, STB_BIN_12H));
    // Century byte absent: fallback century
    send_snapshot(snap(8'h00, 8'h00, 8'h08, 8'h01, 8'h07, 8'h24, 8'h00, STB_BCD_24H));
    // Year before the epoch: only months and days count
    send_snapshot(snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19, STB_BCD_24H));
    // Gregorian leap corners: 2000 leap, 1900 and 2100 common
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h20, STB_BCD_24H));
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h20, STB_BCD_24H));
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h19, STB_BCD_24H));
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21, STB_BCD_24H));
    // Month and day bounds
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h10, 8'h13, 8'h24, 8'h20, STB_BCD_24H));
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h24, 8'h20, STB_BCD_24H));
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h32, 8'h05, 8'h24, 8'h20, STB_BCD_24H));
    send_snapshot(snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h99, STB_BCD_24H));
    // Day past the end of its month counts forward
    send_snapshot(snap(8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h23, 8'h20, STB_BCD_24H));
    // Time fields out of range, hour with bit 7 in 24-hour mode
    send_snapshot(snap(8'h99, 8'h99, 8'h7F, 8'h01, 8'h01, 8'h24, 8'h20, STB_BCD_24H));
    send_snapshot(snap(8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h24, 8'h20, STB_BCD_24H));
    // Largest unsaturated year, then epoch and year saturation
    send_snapshot(snap(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd83, 8'd163, STB_BIN_24H));
    send_snapshot(snap(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd99, 8'd200, STB_BIN_24H));

    // Random phases, each under its own fallback century
    century_plan[0] = 7'd20;
    century_plan[1] = 7'd1;
    century_plan[2] = 7'd100;
    century_plan[3] = 7'd127;
    century_plan[4] = 7'd0;
    century_plan[5] = 7'($urandom_range(1, 100));
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_century(century_plan[p]);
      // Back the pipe up behind a stalled result channel
      if (p == 2) long_hold_req = 1'b1;
      repeat (RANDOM_PER_PHASE) send_snapshot(random_snapshot());
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.failures == 0 && ledger.outstanding() == 0) begin
      $display("rtc_snapshot_to_epoch_seconds_unit test passed");
    end else begin
      $display("rtc_snapshot_to_epoch_seconds_unit test failed");
    end
    $finish;
  end

endmodule
